@@ rtl/core/tmc_pkg.sv @@
// Shared types, constants and helpers for the thermostat mode controller.
package tmc_pkg;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_MEASURE = 2'd1,
		MODE_EDIT    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CFG_DEADBAND    = 3'd0,
		CFG_SP_STEP     = 3'd1,
		CFG_SP_MIN      = 3'd2,
		CFG_SP_MAX      = 3'd3,
		CFG_SP_DEFAULT  = 3'd4
	} cfg_index_t;

	localparam int unsigned ADC_W     = 10;
	localparam int unsigned TEMP_W    = 9;
	localparam int unsigned SP_W      = 8;
	localparam int unsigned DB_W      = 6;
	localparam int unsigned STEP_W    = 5;
	localparam int unsigned SUM_W     = 13;
	localparam int unsigned PCOUNT_W  = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 8;

	localparam logic [ADC_W-1:0] CORR_LOW_LIMIT  = 10'd52;
	localparam logic [ADC_W-1:0] CORR_MID_LIMIT  = 10'd125;

	localparam logic [DB_W-1:0]   DEADBAND_RST   = 6'd5;
	localparam logic [STEP_W-1:0] SP_STEP_RST    = 5'd5;
	localparam logic [SP_W-1:0]   SP_MIN_RST     = 8'd35;
	localparam logic [SP_W-1:0]   SP_MAX_RST     = 8'd75;
	localparam logic [SP_W-1:0]   SP_DEFAULT_RST = 8'd60;

	typedef struct packed {
		logic             step;
		logic             clear;
		logic [TEMP_W-1:0] value;
	} avg_ctl_t;

	typedef struct packed {
		logic              full;
		logic [TEMP_W-1:0] avg;
	} avg_sts_t;

	// Sensor offset correction: halve, then trim by range.
	function automatic logic [TEMP_W-1:0] correct(input logic [ADC_W-1:0] s);
		logic [TEMP_W-1:0] half;
		half = s[ADC_W-1:1];
		if (s < CORR_LOW_LIMIT) begin
			correct = half;
		end else if (s <= CORR_MID_LIMIT) begin
			correct = half - 9'd1;
		end else begin
			correct = half - 9'd2;
		end
	endfunction

endpackage

@@ rtl/core/tmc_avg_window.sv @@
// Moving-average window: sample ring, running sum and reciprocal divide.
module tmc_avg_window #(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmc_pkg::avg_ctl_t  ctl,
	output tmc_pkg::avg_sts_t  sts
);

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SHIFT = tmc_pkg::SUM_W + $clog2(WINDOW);
	localparam int unsigned RECIP = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam int unsigned MUL_W = tmc_pkg::SUM_W + SHIFT;

	logic [tmc_pkg::TEMP_W-1:0] ring_q [WINDOW];
	logic [IDX_W-1:0]           idx_q;
	logic                       full_q;
	logic [tmc_pkg::SUM_W-1:0]  sum_q;

	logic [tmc_pkg::TEMP_W-1:0] old_entry;
	logic [tmc_pkg::SUM_W-1:0]  sum_base;
	logic [tmc_pkg::SUM_W-1:0]  sum_next;
	logic                       wrap;
	logic [IDX_W-1:0]           idx_next;
	logic [MUL_W-1:0]           prod;

	always_comb begin
		old_entry = ring_q[idx_q];
		sum_base  = full_q ? (sum_q - tmc_pkg::SUM_W'(old_entry)) : sum_q;
		sum_next  = sum_base + tmc_pkg::SUM_W'(ctl.value);
		wrap      = (idx_q == IDX_W'(WINDOW - 1));
		idx_next  = wrap ? '0 : idx_q + IDX_W'(1);
		prod      = MUL_W'(sum_next) * MUL_W'(RECIP);
		sts.full  = full_q | wrap;
		sts.avg   = tmc_pkg::TEMP_W'(prod >> SHIFT);
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			ring_q[idx_q] <= ctl.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (ctl.clear) begin
			idx_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (ctl.step) begin
			idx_q  <= idx_next;
			full_q <= full_q | wrap;
			sum_q  <= sum_next;
		end
	end

endmodule

@@ rtl/core/thermostat_mode_controller_core.sv @@
// Thermostat mode controller: off / measure / setpoint edit with deadband drive.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one tick per transaction: a raw
//    10-bit sample and three debounced press flags.
//  - Output channel (out_valid/out_stall) returns exactly one result per tick:
//    display enable and value, heater/cooler/indicator drives and new mode.
//  - out_valid rises once a tick has passed through one input register, then all
//    tick logic (correction, ring update, reciprocal multiply for the average,
//    deadband compare) in a single pass into the result register. Throughput is
//    one tick per cycle while the receiver does not stall.
//  - When the receiver stalls, the result register holds; the input register
//    keeps one more tick and in_stall rises only when both are occupied.
//  - Reset puts the block in off mode, setpoint at 60, registers at their
//    defaults, all drives off. No clearing pass is needed.
//  - Configuration writes (cfg_we/cfg_index/cfg_wdata) are to be made only
//    while idle; the block does not enforce this. CFG_SP_DEFAULT is ignored.
module thermostat_mode_controller_core #(
	parameter int unsigned WINDOW           = 10,
	parameter int unsigned HALF_PHASE_TICKS = 10,
	parameter int unsigned TIMEOUT_PHASES   = 5,
	parameter int unsigned BLINK_PERIOD     = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmc_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tmc_pkg::ADC_W-1:0]       adc_sample,
	input  logic                            power_press,
	input  logic                            up_press,
	input  logic                            down_press,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            display_enable,
	output logic [tmc_pkg::TEMP_W-1:0]      display_value,
	output logic                            heater_on,
	output logic                            cooler_on,
	output logic                            indicator_led,
	output logic [1:0]                      mode_now
);

	localparam int unsigned PT_W = $clog2(HALF_PHASE_TICKS + 1);
	localparam int unsigned BC_W = $clog2(BLINK_PERIOD);

	// configuration
	logic [tmc_pkg::DB_W-1:0]   deadband_q;
	logic [tmc_pkg::STEP_W-1:0] sp_step_q;
	logic [tmc_pkg::SP_W-1:0]   sp_min_q;
	logic [tmc_pkg::SP_W-1:0]   sp_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= tmc_pkg::DEADBAND_RST;
			sp_step_q  <= tmc_pkg::SP_STEP_RST;
			sp_min_q   <= tmc_pkg::SP_MIN_RST;
			sp_max_q   <= tmc_pkg::SP_MAX_RST;
		end else if (cfg_we) begin
			unique case (tmc_pkg::cfg_index_t'(cfg_index))
				tmc_pkg::CFG_DEADBAND: deadband_q <= cfg_wdata[tmc_pkg::DB_W-1:0];
				tmc_pkg::CFG_SP_STEP:  sp_step_q  <= cfg_wdata[tmc_pkg::STEP_W-1:0];
				tmc_pkg::CFG_SP_MIN:   sp_min_q   <= cfg_wdata;
				tmc_pkg::CFG_SP_MAX:   sp_max_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	logic                        valid_s1;
	logic [tmc_pkg::ADC_W-1:0]   adc_s1;
	logic                        pwr_s1;
	logic                        up_s1;
	logic                        dn_s1;
	logic                        out_valid_q;
	logic                        advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			adc_s1 <= adc_sample;
			pwr_s1 <= power_press;
			up_s1  <= up_press;
			dn_s1  <= down_press;
		end
	end

	// controller state
	tmc_pkg::mode_t             mode_q, mode_next;
	logic [tmc_pkg::SP_W-1:0]   sp_q, sp_next;
	logic [BC_W-1:0]            blink_q, blink_next;
	logic                       heat_blink_q, heat_blink_next;
	logic [2:0]                 drive_q, drive_next;
	logic [PT_W-1:0]            pticks_q, pticks_next;
	logic                       blank_q, blank_next;
	logic [tmc_pkg::PCOUNT_W-1:0] pcount_q, pcount_next;

	tmc_pkg::avg_ctl_t          avg_ctl;
	tmc_pkg::avg_sts_t          avg_sts;
	logic [tmc_pkg::TEMP_W-1:0] temp_corr;
	logic                       enter_meas;
	logic                       enter_edit;

	tmc_avg_window #(
		.WINDOW (WINDOW)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (avg_ctl),
		.sts    (avg_sts)
	);

	assign temp_corr = tmc_pkg::correct(adc_s1);

	// edit-mode setpoint arithmetic, phase counters and deadband compare
	logic [tmc_pkg::SP_W:0]     sp_up_sum;
	logic [tmc_pkg::SP_W-1:0]   sp_after_up;
	logic signed [tmc_pkg::SP_W+1:0] sp_dn_diff;
	logic [tmc_pkg::SP_W-1:0]   sp_after_dn;
	logic [PT_W-1:0]            pticks_inc;
	logic [tmc_pkg::PCOUNT_W-1:0] pcount_press;
	logic [tmc_pkg::PCOUNT_W-1:0] pcount_inc;
	logic                       half_done;
	logic signed [tmc_pkg::SP_W+2:0] err;
	logic                       heat_req;
	logic                       cool_req;

	always_comb begin
		sp_up_sum   = {1'b0, sp_q} + (tmc_pkg::SP_W+1)'(sp_step_q);
		sp_after_up = up_s1 ? ((sp_up_sum > {1'b0, sp_max_q}) ? sp_max_q
		                                                      : sp_up_sum[tmc_pkg::SP_W-1:0])
		                    : sp_q;
		sp_dn_diff  = signed'({2'b00, sp_after_up}) - signed'((tmc_pkg::SP_W+2)'(sp_step_q));
		sp_after_dn = dn_s1 ? ((sp_dn_diff < signed'({2'b00, sp_min_q})) ? sp_min_q
		                                              : sp_dn_diff[tmc_pkg::SP_W-1:0])
		                    : sp_after_up;
		pticks_inc   = pticks_q + PT_W'(1);
		half_done    = (pticks_inc >= PT_W'(HALF_PHASE_TICKS));
		pcount_press = (up_s1 || dn_s1) ? '0 : pcount_q;
		pcount_inc   = pcount_press + tmc_pkg::PCOUNT_W'(1);
		err          = signed'({3'b000, sp_q}) - signed'({2'b00, avg_sts.avg});
		heat_req     = (err >= signed'((tmc_pkg::SP_W+3)'(deadband_q)));
		cool_req     = (err <= -signed'((tmc_pkg::SP_W+3)'(deadband_q)));
	end

	// next mode
	always_comb begin
		mode_next  = mode_q;
		enter_meas = 1'b0;
		enter_edit = 1'b0;
		unique case (mode_q)
			tmc_pkg::MODE_MEASURE: begin
				if (pwr_s1) begin
					mode_next = tmc_pkg::MODE_OFF;
				end else if (up_s1 || dn_s1) begin
					mode_next  = tmc_pkg::MODE_EDIT;
					enter_edit = 1'b1;
				end
			end
			tmc_pkg::MODE_EDIT: begin
				if (pwr_s1) begin
					mode_next = tmc_pkg::MODE_OFF;
				end else if (half_done && (pcount_inc >= tmc_pkg::PCOUNT_W'(TIMEOUT_PHASES))) begin
					mode_next  = tmc_pkg::MODE_MEASURE;
					enter_meas = 1'b1;
				end
			end
			default: begin
				mode_next = tmc_pkg::MODE_OFF;
				if (pwr_s1) begin
					mode_next  = tmc_pkg::MODE_MEASURE;
					enter_meas = 1'b1;
				end
			end
		endcase
	end

	// datapath state updates
	always_comb begin
		sp_next         = sp_q;
		blink_next      = blink_q;
		heat_blink_next = heat_blink_q;
		drive_next      = drive_q;
		pticks_next     = pticks_q;
		blank_next      = blank_q;
		pcount_next     = pcount_q;
		avg_ctl.step    = 1'b0;
		avg_ctl.clear   = advance && enter_meas;
		avg_ctl.value   = temp_corr;
		unique case (mode_q)
			tmc_pkg::MODE_MEASURE: begin
				avg_ctl.step = advance;
				if (avg_sts.full) begin
					if (heat_req) begin
						drive_next      = 3'b001;
						heat_blink_next = 1'b1;
					end else if (cool_req) begin
						drive_next      = 3'b110;
						heat_blink_next = 1'b0;
					end else begin
						drive_next      = 3'b000;
						heat_blink_next = 1'b0;
					end
				end
				if (heat_blink_next) begin
					drive_next[2] = (blink_q < BC_W'(BLINK_PERIOD / 2));
				end
				blink_next = (blink_q == BC_W'(BLINK_PERIOD - 1)) ? '0 : blink_q + BC_W'(1);
			end
			tmc_pkg::MODE_EDIT: begin
				pticks_next = pticks_inc;
				if (!pwr_s1) begin
					sp_next     = sp_after_dn;
					pcount_next = pcount_press;
					if (half_done) begin
						pticks_next = '0;
						pcount_next = pcount_inc;
						if (!enter_meas) begin
							blank_next = ~blank_q;
						end
					end
				end
			end
			default: begin
				drive_next = 3'b000;
			end
		endcase
		if (enter_meas) begin
			blink_next      = '0;
			heat_blink_next = 1'b0;
		end
		if (enter_edit) begin
			pticks_next = '0;
			blank_next  = 1'b0;
			pcount_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= tmc_pkg::MODE_OFF;
			sp_q         <= tmc_pkg::SP_DEFAULT_RST;
			blink_q      <= '0;
			heat_blink_q <= 1'b0;
			drive_q      <= 3'b000;
			pticks_q     <= '0;
			blank_q      <= 1'b0;
			pcount_q     <= '0;
		end else if (advance) begin
			mode_q       <= mode_next;
			sp_q         <= sp_next;
			blink_q      <= blink_next;
			heat_blink_q <= heat_blink_next;
			drive_q      <= drive_next;
			pticks_q     <= pticks_next;
			blank_q      <= blank_next;
			pcount_q     <= pcount_next;
		end
	end

	// result fields
	logic                       den;
	logic [tmc_pkg::TEMP_W-1:0] dval;

	always_comb begin
		unique case (mode_q)
			tmc_pkg::MODE_MEASURE: begin
				den  = 1'b1;
				dval = temp_corr;
			end
			tmc_pkg::MODE_EDIT: begin
				den  = ~blank_q;
				dval = tmc_pkg::TEMP_W'(sp_q);
			end
			default: begin
				den  = 1'b0;
				dval = '0;
			end
		endcase
	end

	// result register
	logic                       den_q;
	logic [tmc_pkg::TEMP_W-1:0] dval_q;
	logic [2:0]                 drive_out_q;
	logic [1:0]                 mode_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			den_q       <= den;
			dval_q      <= dval;
			drive_out_q <= drive_next;
			mode_out_q  <= mode_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign display_enable = den_q;
	assign display_value  = dval_q;
	assign heater_on      = drive_out_q[0];
	assign cooler_on      = drive_out_q[1];
	assign indicator_led  = drive_out_q[2];
	assign mode_now       = mode_out_q;

	// checks
	a_no_heat_and_cool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(heater_on && cooler_on))
		else $error("heater and cooler driven together");

	a_cool_lights_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cooler_on |-> indicator_led)
		else $error("cooling without steady indicator");

	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_q == tmc_pkg::MODE_OFF) |=>
			!display_enable && !heater_on && !cooler_on && !indicator_led)
		else $error("off mode result not dark");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with free pipeline");

	a_sp_stable_outside_edit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_q != tmc_pkg::MODE_EDIT) |=> $stable(sp_q))
		else $error("setpoint changed outside edit mode");

endmodule
